[src/ntc_pkg.sv]
package ntc_pkg;

    // default converter resolution
    localparam int ADC_BITS_DEF = 12;

    // result limits in hundredths of a degree
    localparam logic signed [20:0] T_MAX = 21'sd1000000;
    localparam logic signed [20:0] T_MIN = -21'sd27315;
    localparam logic [55:0] CENTIK_MAX = 56'd1027300;
    localparam logic [20:0] CENTI_OFFSET = 21'd27300;

    // status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OFF  = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;
    localparam logic [1:0] ST_SAT  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_SERIES = 2'd0;
    localparam logic [1:0] REG_BETA   = 2'd1;
    localparam logic [1:0] REG_ENABLE = 2'd2;

    // configuration reset values
    localparam logic [19:0] SERIES_RST = 20'd5000;
    localparam logic [13:0] BETA_RST   = 14'd3435;

    // log2 unit: operand width, fraction bits, exponent bits, result width
    localparam int LOG_IN_W = 36;
    localparam int LOG_FB   = 30;
    localparam int LOG_KW   = 6;
    localparam int LOG_W    = LOG_KW + LOG_FB;

    // fixed-point constants
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;
    localparam logic [63:0] INV298_WIDE = ((64'd1 << 48) + 64'd149) / 64'd298;
    localparam logic [55:0] INV298_Q48 = INV298_WIDE[55:0];
    localparam logic [55:0] HUNDRED_Q48 = 56'd100 << 48;

    // divider widths
    localparam int D1_NW = 54;
    localparam int D1_DW = 14;
    localparam int D2_NW = 56;
    localparam int D2_DW = 55;

    // special-case info that rides along with each item
    typedef struct packed {
        logic       spec;
        logic       hi;
        logic [1:0] st;
    } side_t;

    localparam int SIDE_W = $bits(side_t);

endpackage

[src/ntc_log2.sv]
module ntc_log2 import ntc_pkg::*; #(
    parameter int TAG_W = SIDE_W
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                vld_i,
    input  logic [LOG_IN_W-1:0] a_i,
    input  logic [LOG_IN_W-1:0] b_i,
    input  logic [TAG_W-1:0]    tag_i,
    output logic                vld_o,
    output logic [LOG_W-1:0]    la_o,
    output logic [LOG_W-1:0]    lb_o,
    output logic [TAG_W-1:0]    tag_o
);

    logic [LOG_FB:0]    vld_reg;
    logic [TAG_W-1:0]   tag_reg [LOG_FB+1];
    logic [LOG_W-1:0]   res [2];

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LOG_FB-1:0], vld_i};
        end
    end

    // tag line
    always_ff @(posedge aclk) begin
        if (en) begin
            tag_reg[0] <= tag_i;
            for (int i = 1; i <= LOG_FB; i++) begin
                tag_reg[i] <= tag_reg[i-1];
            end
        end
    end

    // two lanes: numerator and denominator
    for (genvar ln = 0; ln < 2; ln++) begin : g_lane
        logic [LOG_IN_W-1:0] v;
        logic [LOG_KW-1:0]   k0;
        logic [LOG_IN_W-1:0] sh;
        logic [LOG_KW-1:0]   k_reg [LOG_FB+1];
        logic [LOG_FB:0]     m_reg [LOG_FB+1];
        logic [LOG_FB-1:0]   f_reg [LOG_FB+1];

        assign v = (ln == 0) ? a_i : b_i;

        // leading one and normalize to [1,2)
        always_comb begin
            k0 = '0;
            for (int i = 0; i < LOG_IN_W; i++) begin
                if (v[i]) begin
                    k0 = LOG_KW'(i);
                end
            end
            if (k0 >= LOG_KW'(LOG_FB)) begin
                sh = v >> (k0 - LOG_KW'(LOG_FB));
            end else begin
                sh = v << (LOG_KW'(LOG_FB) - k0);
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                k_reg[0] <= k0;
                m_reg[0] <= sh[LOG_FB:0];
                f_reg[0] <= '0;
            end
        end

        // one squaring per stage gives one fraction bit
        for (genvar s = 1; s <= LOG_FB; s++) begin : g_sq
            logic [2*LOG_FB+1:0] sq;
            logic [LOG_FB+1:0]   sqh;

            assign sq  = m_reg[s-1] * m_reg[s-1];
            assign sqh = sq[2*LOG_FB+1:LOG_FB];

            always_ff @(posedge aclk) begin
                if (en) begin
                    k_reg[s] <= k_reg[s-1];
                    m_reg[s] <= sqh[LOG_FB+1] ? sqh[LOG_FB+1:1] : sqh[LOG_FB:0];
                    f_reg[s] <= f_reg[s-1] | (LOG_FB'(sqh[LOG_FB+1]) << (LOG_FB - s));
                end
            end
        end

        assign res[ln] = {k_reg[LOG_FB], f_reg[LOG_FB]};
    end

    assign vld_o = vld_reg[LOG_FB];
    assign tag_o = tag_reg[LOG_FB];
    assign la_o  = res[0];
    assign lb_o  = res[1];

endmodule

[src/ntc_div.sv]
module ntc_div import ntc_pkg::*; #(
    parameter int NW    = D1_NW,
    parameter int DW    = D1_DW,
    parameter int TAG_W = SIDE_W
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             vld_i,
    input  logic [NW-1:0]    a_i,
    input  logic [DW-1:0]    b_i,
    input  logic [TAG_W-1:0] tag_i,
    output logic             vld_o,
    output logic [NW-1:0]    q_o,
    output logic [TAG_W-1:0] tag_o
);

    logic [NW-1:0]    vld_reg;
    logic [TAG_W-1:0] tag_reg [NW];
    logic [DW-1:0]    r_reg   [NW];
    logic [NW-1:0]    aq_reg  [NW];
    logic [DW-1:0]    b_reg   [NW];

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NW-2:0], vld_i};
        end
    end

    // restoring division, one quotient bit per stage, msb first
    for (genvar s = 0; s < NW; s++) begin : g_st
        logic [DW-1:0]    rp;
        logic [NW-1:0]    ap;
        logic [DW-1:0]    bp;
        logic [TAG_W-1:0] tp;
        logic [DW:0]      trial;
        logic             ge;

        if (s == 0) begin : g_first
            assign rp = '0;
            assign ap = a_i;
            assign bp = b_i;
            assign tp = tag_i;
        end else begin : g_next
            assign rp = r_reg[s-1];
            assign ap = aq_reg[s-1];
            assign bp = b_reg[s-1];
            assign tp = tag_reg[s-1];
        end

        assign trial = {rp, ap[NW-1]};
        assign ge    = trial >= {1'b0, bp};

        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[s]   <= ge ? DW'(trial - {1'b0, bp}) : trial[DW-1:0];
                aq_reg[s]  <= {ap[NW-2:0], ge};
                b_reg[s]   <= bp;
                tag_reg[s] <= tp;
            end
        end
    end

    assign vld_o = vld_reg[NW-1];
    assign q_o   = aq_reg[NW-1];
    assign tag_o = tag_reg[NW-1];

endmodule

[src/ntc_thermistor_to_temperature_unit.sv]
// NTC thermistor to temperature, Beta equation. Each 12-bit converter sample
// becomes one result: temperature in hundredths of a degree Celsius (21-bit
// two's complement) and a status code (0 ok, 1 sensor disabled, 2 zero sample,
// 3 saturated). The datapath is a 148-stage pipeline that takes one item every
// cycle unless the result side stalls; the depth is set by the two log2 lanes
// (30 squaring stages), the ln/B divider (one quotient bit per stage, 54
// stages) and the Kelvin reciprocal divider (56 stages). A stall on the result
// side holds the whole pipeline. The user must write configuration (index 0
// series resistor, 1 B constant, 2 sensor enable) only while no item is in
// flight; the block does not enforce it. Writes to other indexes are ignored.
module ntc_thermistor_to_temperature_unit import ntc_pkg::*; #(
    parameter int ADC_BITS = ADC_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [11:0]        s_adc_sample,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [20:0] m_temperature_centi,
    output logic [1:0]         m_status,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [19:0]        cfg_data
);

    localparam int SHIFT = 16 - ADC_BITS;
    localparam logic [15:0] SAMPLE_MASK = 16'((32'd1 << ADC_BITS) - 32'd1);

    logic en;

    logic [19:0] series_reg;
    logic [13:0] beta_reg;
    logic        sensor_en_reg;

    logic [15:0] samp16;
    logic [15:0] raw;
    logic [35:0] num_next;
    logic [16:0] comp;
    logic [30:0] den_next;
    side_t       a_side_next;

    logic          a_vld_reg;
    logic [35:0]   a_num_reg;
    logic [35:0]   a_den_reg;
    side_t         a_side_reg;

    logic              lg_vld;
    logic [LOG_W-1:0]  lg_num;
    logic [LOG_W-1:0]  lg_den;
    logic [SIDE_W-1:0] lg_tag;

    logic [36:0] diff;

    logic        l1_vld_reg;
    logic        l1_neg_reg;
    logic [35:0] l1_mag_reg;
    side_t       l1_side_reg;

    logic        l2_vld_reg;
    logic        l2_neg_reg;
    logic [51:0] l2_hi_reg;
    logic [47:0] l2_lo_reg;
    side_t       l2_side_reg;

    logic [51:0] ln_sum;

    logic        l3_vld_reg;
    logic        l3_neg_reg;
    logic [35:0] l3_ln_reg;
    side_t       l3_side_reg;

    logic              d1_vld;
    logic [D1_NW-1:0]  d1_q;
    logic [SIDE_W:0]   d1_tag;

    logic [55:0] qx;
    logic [55:0] y_next;
    side_t       d1_side;
    side_t       y_side_next;

    logic        y_vld_reg;
    logic [55:0] y_reg;
    side_t       y_side_reg;

    logic        dv_vld_reg;
    logic [55:0] dv_num_reg;
    logic [54:0] dv_y_reg;
    side_t       dv_side_reg;

    logic              d2_vld;
    logic [D2_NW-1:0]  d2_q;
    logic [SIDE_W-1:0] d2_tag;

    side_t              d2_side;
    logic signed [20:0] temp_next;
    logic [1:0]         status_next;

    logic               out_vld_reg;
    logic signed [20:0] out_temp_reg;
    logic [1:0]         out_status_reg;

    // pipeline advances whenever the output register is empty or its item is taken
    assign en        = !out_vld_reg || m_ready;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            series_reg    <= SERIES_RST;
            beta_reg      <= BETA_RST;
            sensor_en_reg <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_SERIES: series_reg    <= cfg_data;
                REG_BETA:   beta_reg      <= cfg_data[13:0];
                REG_ENABLE: sensor_en_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // input stage: scale sample, form log2 numerator and denominator
    always_comb begin
        samp16   = {4'd0, s_adc_sample} & SAMPLE_MASK;
        raw      = samp16 << SHIFT;
        num_next = 36'({16'd0, series_reg} * {20'd0, raw});
        comp     = 17'h10000 - {1'b0, raw};
        den_next = 31'({14'd0, comp} * 31'd10000);
        a_side_next = '{spec: 1'b0, hi: 1'b0, st: ST_OK};
        if (!sensor_en_reg) begin
            a_side_next = '{spec: 1'b1, hi: 1'b0, st: ST_OFF};
        end else if (num_next == '0) begin
            a_side_next = '{spec: 1'b1, hi: 1'b0, st: ST_ZERO};
        end else if (beta_reg == '0) begin
            a_side_next = '{spec: 1'b1, hi: 1'b0, st: ST_SAT};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_num_reg  <= num_next;
            a_den_reg  <= {5'd0, den_next};
            a_side_reg <= a_side_next;
        end
    end

    // log2 of numerator and denominator
    ntc_log2 #(.TAG_W(SIDE_W)) u_log2 (
        .aclk   (aclk),
        .aresetn(aresetn),
        .en     (en),
        .vld_i  (a_vld_reg),
        .a_i    (a_num_reg),
        .b_i    (a_den_reg),
        .tag_i  (a_side_reg),
        .vld_o  (lg_vld),
        .la_o   (lg_num),
        .lb_o   (lg_den),
        .tag_o  (lg_tag)
    );

    // log2 difference, split into sign and magnitude
    assign diff = {1'b0, lg_num} - {1'b0, lg_den};

    always_ff @(posedge aclk) begin
        if (en) begin
            l1_neg_reg  <= diff[36];
            l1_mag_reg  <= diff[36] ? 36'(-diff) : diff[35:0];
            l1_side_reg <= side_t'(lg_tag);
        end
    end

    // times ln2, two partial products
    always_ff @(posedge aclk) begin
        if (en) begin
            l2_neg_reg  <= l1_neg_reg;
            l2_hi_reg   <= 52'(l1_mag_reg[35:16] * LN2_Q32);
            l2_lo_reg   <= 48'(l1_mag_reg[15:0] * LN2_Q32);
            l2_side_reg <= l1_side_reg;
        end
    end

    assign ln_sum = l2_hi_reg + {20'd0, l2_lo_reg[47:16]};

    always_ff @(posedge aclk) begin
        if (en) begin
            l3_neg_reg  <= l2_neg_reg;
            l3_ln_reg   <= ln_sum[51:16];
            l3_side_reg <= l2_side_reg;
        end
    end

    // |ln x| / B in Q48
    ntc_div #(.NW(D1_NW), .DW(D1_DW), .TAG_W(SIDE_W + 1)) u_div_ln (
        .aclk   (aclk),
        .aresetn(aresetn),
        .en     (en),
        .vld_i  (l3_vld_reg),
        .a_i    ({l3_ln_reg, 18'd0}),
        .b_i    (beta_reg),
        .tag_i  ({l3_neg_reg, l3_side_reg}),
        .vld_o  (d1_vld),
        .q_o    (d1_q),
        .tag_o  (d1_tag)
    );

    // y = ln(x)/B + 1/298, flag non-positive y
    always_comb begin
        qx      = {2'd0, d1_q};
        d1_side = side_t'(d1_tag[SIDE_W-1:0]);
        y_next  = d1_tag[SIDE_W] ? INV298_Q48 - qx : INV298_Q48 + qx;
        y_side_next = d1_side;
        if (!d1_side.spec && (y_next[55] || y_next == '0)) begin
            y_side_next = '{spec: 1'b1, hi: 1'b1, st: ST_SAT};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            y_reg      <= y_next;
            y_side_reg <= y_side_next;
        end
    end

    // rounded reciprocal numerator
    always_ff @(posedge aclk) begin
        if (en) begin
            dv_num_reg  <= HUNDRED_Q48 + {1'b0, y_reg[55:1]};
            dv_y_reg    <= y_reg[54:0];
            dv_side_reg <= y_side_reg;
        end
    end

    // Kelvin in hundredths
    ntc_div #(.NW(D2_NW), .DW(D2_DW), .TAG_W(SIDE_W)) u_div_k (
        .aclk   (aclk),
        .aresetn(aresetn),
        .en     (en),
        .vld_i  (dv_vld_reg),
        .a_i    (dv_num_reg),
        .b_i    (dv_y_reg),
        .tag_i  (dv_side_reg),
        .vld_o  (d2_vld),
        .q_o    (d2_q),
        .tag_o  (d2_tag)
    );

    // offset to Celsius and saturate
    always_comb begin
        d2_side = side_t'(d2_tag);
        if (d2_side.spec) begin
            temp_next   = d2_side.hi ? T_MAX : T_MIN;
            status_next = d2_side.st;
        end else if (d2_q > CENTIK_MAX) begin
            temp_next   = T_MAX;
            status_next = ST_SAT;
        end else begin
            temp_next   = $signed(d2_q[20:0] - CENTI_OFFSET);
            status_next = ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_temp_reg   <= temp_next;
            out_status_reg <= status_next;
        end
    end

    // valid bits of the top-level stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg   <= 1'b0;
            l1_vld_reg  <= 1'b0;
            l2_vld_reg  <= 1'b0;
            l3_vld_reg  <= 1'b0;
            y_vld_reg   <= 1'b0;
            dv_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else if (en) begin
            a_vld_reg   <= s_valid;
            l1_vld_reg  <= lg_vld;
            l2_vld_reg  <= l1_vld_reg;
            l3_vld_reg  <= l2_vld_reg;
            y_vld_reg   <= d1_vld;
            dv_vld_reg  <= y_vld_reg;
            out_vld_reg <= d2_vld;
        end
    end

    assign m_valid             = out_vld_reg;
    assign m_temperature_centi = out_temp_reg;
    assign m_status            = out_status_reg;

endmodule

[src/ntc_chk.sv]
module ntc_chk import ntc_pkg::*; (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [20:0] m_temperature_centi,
    input logic [1:0]         m_status
);

    // no item shows right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a stalled item stays
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_temperature_centi) && $stable(m_status))
        else $error("stalled item changed");

    // input side is held only while output side is stalled
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without output stall");

    // disabled sensor and zero sample read absolute zero
    a_abs_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_OFF || m_status == ST_ZERO) |-> m_temperature_centi == T_MIN)
        else $error("special status with wrong temperature");

    // saturated items sit at a rail
    a_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_SAT |-> m_temperature_centi == T_MAX ||
            m_temperature_centi == T_MIN)
        else $error("saturated item off the rails");

endmodule

bind ntc_thermistor_to_temperature_unit ntc_chk u_ntc_chk (.*);
